FILE: rtl/rwtc_pkg.sv
`timescale 1ns / 1ps
// shared constants and codes for the register write trace codec
package rwtc_pkg;

	localparam int TRACE_DEPTH = 65536; // power of two
	localparam int TRACE_AW    = $clog2(TRACE_DEPTH);
	localparam int POS_W       = TRACE_AW + 1;

	localparam int GAP_W       = 17;
	localparam int CNT_W       = 16;
	localparam int TOTAL_W     = 32;

	localparam int S_DATA_W    = 40;
	localparam int M_DATA_W    = 56;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 17;

	localparam logic [GAP_W-1:0] GAP_MAX  = GAP_W'(65536);
	localparam logic [GAP_W-1:0] LONG_GAP = GAP_W'(256);

	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DUMP_LENGTH = 1'b1;

	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_CAPTURE = 2'd1;
	localparam logic [1:0] MODE_PLAY    = 2'd2;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	localparam logic KIND_TRACE = 1'b0;
	localparam logic KIND_PLAY  = 1'b1;

	localparam logic [2:0] SHORT_REC_LEN = 3'd3;
	localparam logic [2:0] LONG_REC_LEN  = 3'd4;

endpackage

FILE: rtl/register_write_trace_codec.sv
`timescale 1ns / 1ps
// register write trace codec: capture encoder, trace memory and replay sequencer
// a record's bytes leave the item buffer via the output register, one a cycle unless stalled
// loads and ticks that need no record read or emit do not hold off the next item
// a replay tick that reads a record stalls input for its four reads on the one memory read port
// a capture tick with a write stalls input until its 3 or 4 record bytes reach the output register
// reset clears control state and counters; the trace memory is not cleared and holds what was loaded
module register_write_trace_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// write_valid, write_reg, write_value, load_addr, load_byte, zero pad
	input  logic [rwtc_pkg::S_DATA_W-1:0] s_tdata,
	// func
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// trace_byte, played_reg, played_value, tick_total, zero pad
	output logic [rwtc_pkg::M_DATA_W-1:0] m_tdata,
	// out_kind
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rwtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rwtc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rwtc_pkg::*;

	logic [1:0]            mode_q;
	logic [CFG_DATA_W-1:0] dump_len_q;
	logic [GAP_W-1:0]      gap_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [POS_W-1:0]      pos_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [4:0]            held_reg_q;
	logic [7:0]            held_val_q;

	logic [7:0] trace_mem [TRACE_DEPTH];
	logic [7:0] mem_rd_q;

	logic       rd_active_q;
	logic       rd_fire_q;
	logic [2:0] rd_step_q;
	logic [7:0] rd_b0_q;
	logic [7:0] rd_b1_q;
	logic [7:0] rd_b2_q;

	logic [2:0] ob_left_q;
	logic [1:0] ob_idx_q;
	logic       ob_kind_q;
	logic [7:0] ob_byte_q [4];
	logic [4:0] ob_reg_q;
	logic [7:0] ob_val_q;

	logic               m_tvalid_q;
	logic               m_kind_q;
	logic [7:0]         m_byte_q;
	logic               m_last_q;
	logic [4:0]         m_reg_q;
	logic [7:0]         m_val_q;
	logic [TOTAL_W-1:0] m_total_q;

	logic                in_acc;
	logic                wv;
	logic [4:0]          wreg;
	logic [7:0]          wval;
	logic [15:0]         laddr;
	logic [7:0]          lbyte;
	logic                load_acc;
	logic                cap_tick;
	logic                cap_rec;
	logic                play_tick;
	logic                pos_zero;
	logic                cnt_gt1;
	logic                play_fire;
	logic                rd_start;
	logic                rd_issue;
	logic                rd_done;
	logic                rd_short;
	logic [POS_W-1:0]    rd_addr_full;
	logic [TRACE_AW-1:0] rd_addr;
	logic [POS_W-1:0]    new_pos;
	logic [POS_W-1:0]    play_len;
	logic                gap_long;
	logic [15:0]         gap_word;
	logic                busy;
	logic                out_free;
	logic                ob_pop;
	logic                cfg_acc;

	assign wv    = s_tdata[0];
	assign wreg  = s_tdata[5:1];
	assign wval  = s_tdata[13:6];
	assign laddr = s_tdata[29:14];
	assign lbyte = s_tdata[37:30];

	assign busy      = (ob_left_q != 3'd0) || rd_active_q;
	assign s_tready  = !busy;
	assign in_acc    = s_tvalid && s_tready;
	assign load_acc  = in_acc && (s_tuser == FUNC_LOAD);
	assign cap_tick  = in_acc && (s_tuser == FUNC_TICK) && (mode_q == MODE_CAPTURE);
	assign cap_rec   = cap_tick && wv;
	assign play_tick = in_acc && (s_tuser == FUNC_TICK) && (mode_q == MODE_PLAY);

	assign pos_zero  = (pos_q == '0);
	assign cnt_gt1   = (cnt_q > CNT_W'(1));
	assign play_fire = play_tick && !pos_zero && !cnt_gt1;
	assign rd_start  = play_tick && (pos_zero || !cnt_gt1);

	assign rd_done      = rd_active_q && (rd_step_q == 3'd4);
	assign rd_issue     = rd_start || (rd_active_q && (rd_step_q != 3'd4));
	assign rd_addr_full = rd_start ? pos_q : pos_q + POS_W'(rd_step_q);
	assign rd_addr      = rd_addr_full[TRACE_AW-1:0];
	assign rd_short     = (rd_b0_q[7:5] == 3'd0);
	assign new_pos      = pos_q + POS_W'(rd_short ? SHORT_REC_LEN : LONG_REC_LEN);
	assign play_len     = (dump_len_q > CFG_DATA_W'(TRACE_DEPTH)) ? POS_W'(TRACE_DEPTH)
	                                                              : POS_W'(dump_len_q);

	assign gap_long = (gap_q >= LONG_GAP);
	assign gap_word = gap_q[GAP_W-1] ? 16'hFFFF : gap_q[15:0];

	assign out_free = !m_tvalid_q || m_tready;
	assign ob_pop   = (ob_left_q != 3'd0) && out_free;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// trace memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (load_acc) begin
			trace_mem[laddr[TRACE_AW-1:0]] <= lbyte;
		end
		if (rd_issue) begin
			mem_rd_q <= trace_mem[rd_addr];
		end
	end

	// configuration, capture counters and replay position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			dump_len_q <= '0;
			gap_q      <= '0;
			total_q    <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			held_reg_q <= '0;
			held_val_q <= '0;
		end else begin
			if (cfg_acc && (cfg_index == REG_MODE)) begin
				mode_q <= cfg_data[1:0];
				pos_q  <= '0;
				gap_q  <= '0;
				cnt_q  <= '0;
			end
			if (cfg_acc && (cfg_index == REG_DUMP_LENGTH)) begin
				dump_len_q <= cfg_data;
			end
			if (cap_tick) begin
				total_q <= total_q + TOTAL_W'(1);
				if (!wv) begin
					if (gap_q != GAP_MAX) begin
						gap_q <= gap_q + GAP_W'(1);
					end
				end else begin
					gap_q <= '0;
				end
			end
			if (play_tick && !pos_zero && cnt_gt1) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (rd_done) begin
				held_reg_q <= rd_b0_q[4:0];
				held_val_q <= rd_b1_q;
				if (rd_fire_q && (new_pos >= play_len)) begin
					pos_q <= '0;
					cnt_q <= '0;
				end else begin
					pos_q <= new_pos;
					cnt_q <= rd_short ? {8'h00, rd_b2_q} : {mem_rd_q, rd_b2_q};
				end
			end
		end
	end

	// record read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_active_q <= 1'b0;
			rd_fire_q   <= 1'b0;
			rd_step_q   <= '0;
		end else if (rd_start) begin
			rd_active_q <= 1'b1;
			rd_fire_q   <= play_fire;
			rd_step_q   <= 3'd1;
		end else if (rd_active_q) begin
			if (rd_step_q == 3'd4) begin
				rd_active_q <= 1'b0;
			end else begin
				rd_step_q <= rd_step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_active_q) begin
			case (rd_step_q)
				3'd1: begin
					rd_b0_q <= mem_rd_q;
				end
				3'd2: begin
					rd_b1_q <= mem_rd_q;
				end
				3'd3: begin
					rd_b2_q <= mem_rd_q;
				end
				default: begin
				end
			endcase
		end
	end

	// item buffer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_left_q  <= '0;
			ob_idx_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cap_rec) begin
				ob_left_q <= gap_long ? LONG_REC_LEN : SHORT_REC_LEN;
				ob_idx_q  <= '0;
			end else if (play_fire) begin
				ob_left_q <= 3'd1;
				ob_idx_q  <= '0;
			end else if (ob_pop) begin
				ob_left_q <= ob_left_q - 3'd1;
				ob_idx_q  <= ob_idx_q + 2'd1;
			end
			if (out_free) begin
				m_tvalid_q <= (ob_left_q != 3'd0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap_rec) begin
			ob_kind_q    <= KIND_TRACE;
			ob_byte_q[0] <= {2'b00, gap_long, wreg};
			ob_byte_q[1] <= wval;
			ob_byte_q[2] <= gap_word[7:0];
			ob_byte_q[3] <= gap_word[15:8];
			ob_reg_q     <= '0;
			ob_val_q     <= '0;
		end else if (play_fire) begin
			ob_kind_q    <= KIND_PLAY;
			ob_byte_q[0] <= '0;
			ob_reg_q     <= held_reg_q;
			ob_val_q     <= held_val_q;
		end
		if (ob_pop) begin
			m_kind_q  <= ob_kind_q;
			m_byte_q  <= ob_byte_q[ob_idx_q];
			m_last_q  <= (ob_left_q == 3'd1);
			m_reg_q   <= ob_reg_q;
			m_val_q   <= ob_val_q;
			m_total_q <= total_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {3'b000, m_total_q, m_val_q, m_reg_q, m_byte_q};

`ifndef SYNTHESIS
	a_play_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_PLAY)) |-> m_tlast)
		else $error("replayed write without last flag");

	a_trace_no_play_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_TRACE)) |-> (m_tdata[20:8] == 13'd0))
		else $error("trace byte carries replay fields");

	a_buffer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_left_q <= LONG_REC_LEN)
		else $error("item buffer overrun");

	a_read_steps: assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> ((rd_step_q >= 3'd1) && (rd_step_q <= 3'd4)))
		else $error("record read step out of range");

	a_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rd_done |=> !rd_active_q)
		else $error("record read did not finish");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> !in_acc)
		else $error("item accepted during record read");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the register write trace codec: capture records and replay
module tb_top;
	import rwtc_pkg::*;

	localparam int          RAND_ITEMS    = 30;
	localparam int          SETTLE_CYCLES = 12;
	localparam int          HOLD_CYCLES   = 200;
	localparam int unsigned LIMIT_CYCLES  = 1000000;
	localparam logic [1:0]  MODE_UNUSED   = 2'd3;

	typedef struct packed {
		logic        func;
		logic        wv;
		logic [4:0]  wreg;
		logic [7:0]  wval;
		logic [15:0] laddr;
		logic [7:0]  lbyte;
		logic [2:0]  idle;
	} codec_in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tbyte;
		logic        last;
		logic [4:0]  preg;
		logic [7:0]  pval;
		logic [31:0] ticks;
	} codec_out_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor state
	logic [1:0]            cur_mode = MODE_OFF;
	logic [POS_W-1:0]      dump_len = '0;
	logic [GAP_W-1:0]      gap_cnt  = '0;
	logic [TOTAL_W-1:0]    tick_cnt = '0;
	logic [POS_W-1:0]      play_pos = '0;
	logic [17:0]           play_cnt = '0;
	logic [4:0]            held_reg = '0;
	logic [7:0]            held_val = '0;
	logic [7:0]            mem_img [TRACE_DEPTH];

	codec_in_t             pending_ops [$];
	codec_out_t            predicted_out_q [$];
	codec_in_t             drv_op;
	codec_in_t             seen_op;
	codec_out_t            want_out;
	int                    n_sent    = 0;
	int                    n_acc     = 0;
	int                    fail_cnt  = 0;
	int                    send_wait = 0;
	int                    ready_wait = 0;
	int                    hold_left = 0;
	int                    rx_draw;
	int                    rec_end;
	int                    n_recs;
	bit                    hold_done = 1'b0;
	bit                    hold_req  = 1'b0;
	bit                    no_idle   = 1'b0;
	int unsigned           cycle_cnt = 0;

	register_write_trace_codec u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void push_out(input logic kind, input logic [7:0] tbyte,
			input logic last, input logic [4:0] preg, input logic [7:0] pval);
		codec_out_t o;
		o.kind  = kind;
		o.tbyte = tbyte;
		o.last  = last;
		o.preg  = preg;
		o.pval  = pval;
		o.ticks = tick_cnt;
		predicted_out_q.push_back(o);
	endfunction

	function automatic void fetch_record();
		logic [7:0] head;
		head     = mem_img[play_pos[TRACE_AW-1:0]];
		held_val = mem_img[TRACE_AW'(play_pos + 17'd1)];
		if (head[7:5] == 3'd0) begin
			play_cnt = 18'(mem_img[TRACE_AW'(play_pos + 17'd2)]);
			play_pos = play_pos + POS_W'(SHORT_REC_LEN);
		end else begin
			play_cnt = {2'b00, mem_img[TRACE_AW'(play_pos + 17'd3)],
				mem_img[TRACE_AW'(play_pos + 17'd2)]};
			play_pos = play_pos + POS_W'(LONG_REC_LEN);
		end
		held_reg = head[4:0];
	endfunction

	task automatic predict_codec_out(input codec_in_t op);
		logic [GAP_W-1:0] gap;
		logic             lng;
		logic [POS_W-1:0] wrap_at;
		logic [4:0]       out_reg;
		logic [7:0]       out_val;
		if (op.func == FUNC_LOAD) begin
			mem_img[op.laddr] = op.lbyte;
		end else if (cur_mode == MODE_CAPTURE) begin
			tick_cnt = tick_cnt + 32'd1;
			if (!op.wv) begin
				if (gap_cnt < GAP_MAX)
					gap_cnt = gap_cnt + GAP_W'(1);
			end else begin
				lng     = (gap_cnt >= LONG_GAP);
				gap     = (gap_cnt > GAP_MAX - GAP_W'(1)) ? GAP_MAX - GAP_W'(1) : gap_cnt;
				gap_cnt = '0;
				push_out(KIND_TRACE, {2'b00, lng, op.wreg}, 1'b0, 5'd0, 8'd0);
				push_out(KIND_TRACE, op.wval, 1'b0, 5'd0, 8'd0);
				push_out(KIND_TRACE, gap[7:0], !lng, 5'd0, 8'd0);
				if (lng)
					push_out(KIND_TRACE, gap[15:8], 1'b1, 5'd0, 8'd0);
			end
		end else if (cur_mode == MODE_PLAY) begin
			wrap_at = (dump_len > POS_W'(TRACE_DEPTH)) ? POS_W'(TRACE_DEPTH) : dump_len;
			if (play_pos == '0) begin
				fetch_record();
			end else if (play_cnt > 18'd1) begin
				play_cnt = play_cnt - 18'd1;
			end else begin
				out_reg = held_reg;
				out_val = held_val;
				fetch_record();
				if (play_pos >= wrap_at) begin
					play_pos = '0;
					play_cnt = '0;
				end
				push_out(KIND_PLAY, 8'd0, 1'b1, out_reg, out_val);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			s_tuser   <= 1'b0;
			send_wait <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_wait != 0) begin
				s_tvalid  <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending_ops.size() != 0) begin
				drv_op = pending_ops.pop_front();
				s_tvalid  <= 1'b1;
				s_tuser   <= drv_op.func;
				s_tdata   <= {2'b00, drv_op.lbyte, drv_op.laddr, drv_op.wval, drv_op.wreg,
					drv_op.wv};
				send_wait <= int'(drv_op.idle);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// accepted items feed the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			seen_op.func  = s_tuser;
			seen_op.wv    = s_tdata[0];
			seen_op.wreg  = s_tdata[5:1];
			seen_op.wval  = s_tdata[13:6];
			seen_op.laddr = s_tdata[29:14];
			seen_op.lbyte = s_tdata[37:30];
			seen_op.idle  = '0;
			predict_codec_out(seen_op);
			n_acc++;
		end
	end

	// receiver ready with per-item waits and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_wait <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_tready  <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (ready_wait != 0) begin
			m_tready   <= 1'b0;
			ready_wait <= ready_wait - 1;
		end else if (m_tvalid && m_tready) begin
			rx_draw = no_idle ? 0 : $urandom_range(0, 5);
			m_tready   <= (rx_draw == 0);
			ready_wait <= (rx_draw == 0) ? 0 : rx_draw - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_out_q.size() == 0) begin
				$display("%0t: unexpected result expected none got %h", $time, m_tdata);
				fail_cnt++;
			end else begin
				want_out = predicted_out_q.pop_front();
				check_field("out_kind", 32'(want_out.kind), 32'(m_tuser));
				check_field("trace_byte", 32'(want_out.tbyte), 32'(m_tdata[7:0]));
				check_field("last_of_run", 32'(want_out.last), 32'(m_tlast));
				check_field("played_reg", 32'(want_out.preg), 32'(m_tdata[12:8]));
				check_field("played_value", 32'(want_out.pval), 32'(m_tdata[20:13]));
				check_field("tick_total", want_out.ticks, m_tdata[52:21]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void queue_op(input codec_in_t op);
		op.idle = no_idle ? 3'd0 : 3'($urandom_range(0, 5));
		pending_ops.push_back(op);
		n_sent++;
	endfunction

	function automatic void send_tick(input logic wv, input logic [4:0] wreg,
			input logic [7:0] wval);
		codec_in_t op;
		op.func  = FUNC_TICK;
		op.wv    = wv;
		op.wreg  = wreg;
		op.wval  = wval;
		op.laddr = 16'($urandom);
		op.lbyte = 8'($urandom);
		op.idle  = '0;
		queue_op(op);
	endfunction

	function automatic void send_load(input logic [15:0] addr, input logic [7:0] data);
		codec_in_t op;
		op.func  = FUNC_LOAD;
		op.wv    = 1'($urandom);
		op.wreg  = 5'($urandom);
		op.wval  = 8'($urandom);
		op.laddr = addr;
		op.lbyte = data;
		op.idle  = '0;
		queue_op(op);
	endfunction

	function automatic void send_idle_ticks(input int n);
		repeat (n) send_tick(1'b0, 5'($urandom), 8'($urandom));
	endfunction

	function automatic void send_rand_op();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			send_load(16'($urandom), 8'($urandom));
		else
			send_tick(r < 4, 5'($urandom), 8'($urandom));
	endfunction

	function automatic void put_record(input logic [7:0] head, input logic [7:0] val,
			input logic [15:0] gap);
		send_load(16'(rec_end), head);
		send_load(16'(rec_end + 1), val);
		send_load(16'(rec_end + 2), gap[7:0]);
		if (head[7:5] != 3'd0) begin
			send_load(16'(rec_end + 3), gap[15:8]);
			rec_end += 4;
		end else begin
			rec_end += 3;
		end
		n_recs++;
	endfunction

	task automatic wait_idle();
		while (n_acc != n_sent || predicted_out_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_MODE) begin
			cur_mode = val[1:0];
			play_pos = '0;
			gap_cnt  = '0;
			play_cnt = '0;
		end else begin
			dump_len = val;
		end
		@(negedge clk);
	endtask

	initial begin
		logic [7:0]       head;
		logic [15:0]      gap;
		logic [POS_W-1:0] play_len;
		int               k;
		int               t;
		int               sel;
		int               base;
		bit               first_cap;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// off and unused modes ignore ticks, loads work anywhere
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_OFF));
		send_tick(1'b1, 5'd31, 8'hFF);
		send_load(16'hFFFF, 8'hFF);
		send_tick(1'b0, 5'd0, 8'h00);
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_UNUSED));
		send_tick(1'b1, 5'd7, 8'h81);
		send_tick(1'b0, 5'd3, 8'h18);

		// capture: zero gap and a long gap
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_CAPTURE));
		send_tick(1'b1, 5'd31, 8'hFF);
		send_tick(1'b1, 5'd0, 8'h00);
		send_load(16'h0000, 8'h00);
		send_idle_ticks(256);
		send_tick(1'b1, 5'h0A, 8'h93);
		send_idle_ticks(3);
		// rewriting the mode clears the gap
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_CAPTURE));
		send_tick(1'b1, 5'h01, 8'hFE);

		// replay: expiry at gaps 0 and 1, long records, a two-byte countdown
		rec_end = 0;
		n_recs  = 0;
		put_record(8'h1F, 8'hFF, 16'd0);
		put_record(8'h00, 8'h00, 16'd1);
		put_record(8'h05, 8'hA5, 16'd2);
		put_record(8'h2A, 8'h3C, 16'h0000);
		put_record(8'h11, 8'h77, 16'd3);
		put_record(8'hE3, 8'h5A, 16'h0102);
		cfg_write(REG_DUMP_LENGTH, CFG_DATA_W'(rec_end));
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_PLAY));
		no_idle = 1'b1;
		repeat (30) send_tick(1'($urandom), 5'($urandom), 8'($urandom));
		no_idle = 1'b0;
		cfg_write(REG_DUMP_LENGTH, '0);
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_PLAY));
		repeat (8) send_tick(1'($urandom), 5'($urandom), 8'($urandom));
		// dump lengths past the loaded records: keep reads inside them
		cfg_write(REG_DUMP_LENGTH, CFG_DATA_W'(TRACE_DEPTH));
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_PLAY));
		repeat (n_recs) send_tick(1'($urandom), 5'($urandom), 8'($urandom));
		cfg_write(REG_DUMP_LENGTH, '1);
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_PLAY));
		repeat (n_recs) send_tick(1'($urandom), 5'($urandom), 8'($urandom));

		base      = n_sent;
		first_cap = 1'b1;
		while (n_sent - base < RAND_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			sel     = first_cap ? 0 : $urandom_range(0, 9);
			if (sel < 5) begin
				cfg_write(REG_MODE, CFG_DATA_W'(MODE_CAPTURE));
				if (first_cap) begin
					no_idle  = 1'b0;
					hold_req = 1'b1;
				end
				first_cap = 1'b0;
				repeat ($urandom_range(15, 35)) send_rand_op();
				if ($urandom_range(0, 3) == 0)
					send_idle_ticks($urandom_range(1, 20));
				send_tick(1'b1, 5'($urandom), 8'($urandom));
			end else if (sel < 9) begin
				rec_end = 0;
				n_recs  = 0;
				k       = $urandom_range(2, 8);
				repeat (k) begin
					if ($urandom_range(0, 3) == 0) begin
						head = {3'($urandom_range(1, 7)), 5'($urandom)};
						gap  = {8'd0, 8'($urandom_range(0, 5))};
					end else begin
						head = {3'b000, 5'($urandom)};
						gap  = 16'($urandom_range(0, 5));
					end
					put_record(head, 8'($urandom), gap);
				end
				case ($urandom_range(0, 5))
					0: play_len = POS_W'($urandom_range(0, rec_end));
					1: play_len = POS_W'(TRACE_DEPTH);
					2: play_len = '1;
					default: play_len = POS_W'(rec_end);
				endcase
				cfg_write(REG_DUMP_LENGTH, play_len);
				cfg_write(REG_MODE, CFG_DATA_W'(MODE_PLAY));
				t = (play_len > rec_end) ? k : $urandom_range(10, 30);
				repeat (t) begin
					if ($urandom_range(0, 7) == 0)
						send_load(16'($urandom_range(rec_end, 65535)), 8'($urandom));
					send_tick(1'($urandom), 5'($urandom), 8'($urandom));
				end
			end else begin
				cfg_write(REG_MODE,
					CFG_DATA_W'(($urandom_range(0, 1) != 0) ? MODE_OFF : MODE_UNUSED));
				repeat ($urandom_range(6, 12)) send_rand_op();
			end
		end

		wait_idle();
		if (fail_cnt == 0 && predicted_out_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
